### sv/hcbd_pkg.sv
// ---------------------------------------------------------------------------
// hcbd_pkg
// Shared types, codes and helpers of the chunked body decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam int unsigned CFG_W      = 32;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned ACC_W      = 33;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BODY  = 1'b1;

	localparam logic [CFG_W-1:0] MAX_CHUNK_RESET = 32'd16777216;
	localparam logic [CFG_W-1:0] MAX_BODY_RESET  = 32'd67108864;

	localparam logic [1:0] STAT_RUN   = 2'd0;
	localparam logic [1:0] STAT_DONE  = 2'd1;
	localparam logic [1:0] STAT_ERROR = 2'd2;

	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_TAB  = 8'h09;

	// saturation value of the size accumulator, 2^32
	localparam logic [ACC_W-1:0] ACC_SAT = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [CFG_W-1:0] SKIP_BYTES = 32'd2;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_SKIP,
		PH_TRAILER,
		PH_DONE,
		PH_FAILED
	} phase_t;

	typedef struct packed {
		logic       is_cr;
		logic       is_lf;
		logic       is_semi;
		logic       is_space;
		logic       is_hex;
		logic [3:0] hex_val;
	} byte_class_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        new_msg;
		byte_class_t cls;
	} queue_entry_t;

	typedef struct packed {
		logic ext;
		logic digit;
		logic tail;
		logic bad;
	} size_flags_t;

	typedef struct packed {
		size_flags_t flags;
		logic        take_digit;
	} line_step_t;

	localparam byte_class_t CR_CLASS = '{
		is_cr: 1'b1, is_lf: 1'b0, is_semi: 1'b0, is_space: 1'b1,
		is_hex: 1'b0, hex_val: 4'd0
	};

	// one character of the size line
	function automatic line_step_t line_char(size_flags_t f, byte_class_t c);
		line_step_t r;
		r.flags      = f;
		r.take_digit = 1'b0;
		if (!f.ext) begin
			if (c.is_semi) begin
				r.flags.ext = 1'b1;
			end else if (c.is_space) begin
				if (f.digit) r.flags.tail = 1'b1;
			end else if (!c.is_hex || f.tail) begin
				r.flags.bad = 1'b1;
			end else begin
				r.flags.digit = 1'b1;
				r.take_digit  = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/hcbd_if.sv
// ---------------------------------------------------------------------------
// hcbd_if
// Valid/ready channels of the chunked body decoder: raw body in, payload out.
// ---------------------------------------------------------------------------
`default_nettype none

interface hcbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_message;

	modport source (output valid, output data_byte, output new_message, input ready);
	modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

interface hcbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic [1:0] status;

	modport source (output valid, output payload_byte, output payload_valid,
		output status, input ready);
	modport sink   (input valid, input payload_byte, input payload_valid,
		input status, output ready);
endinterface

`default_nettype wire

### sv/hcbd_front.sv
// ---------------------------------------------------------------------------
// hcbd_front
// Takes raw body bytes and tags each with its character class for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module hcbd_front (
	hcbd_in_if.sink                body,
	input  wire logic              full,
	output logic                   push,
	output hcbd_pkg::queue_entry_t entry
);
	import hcbd_pkg::*;

	logic [7:0]  b;
	byte_class_t cls;
	logic        is_digit;
	logic        is_lower;
	logic        is_upper;

	assign b          = body.data_byte;
	assign body.ready = !full;
	assign push       = body.valid && !full;

	always_comb begin
		is_digit     = (b >= 8'h30) && (b <= 8'h39);
		is_lower     = (b >= 8'h61) && (b <= 8'h66);
		is_upper     = (b >= 8'h41) && (b <= 8'h46);
		cls.is_cr    = (b == CH_CR);
		cls.is_lf    = (b == CH_LF);
		cls.is_semi  = (b == CH_SEMI);
		cls.is_space = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
		cls.is_hex   = is_digit || is_lower || is_upper;
		// letters a-f and A-F share the low nibble 1..6
		cls.hex_val  = is_digit ? b[3:0] : 4'(b[3:0] + 4'd9);
	end

	always_comb begin
		entry.data    = b;
		entry.new_msg = body.new_message;
		entry.cls     = cls;
	end

endmodule

`default_nettype wire

### sv/hcbd_queue.sv
// ---------------------------------------------------------------------------
// hcbd_queue
// Small first-in first-out buffer between the classifier and the decoder.
// ---------------------------------------------------------------------------
`default_nettype none

module hcbd_queue #(
	parameter int unsigned Depth = hcbd_pkg::QUEUE_DEPTH
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire hcbd_pkg::queue_entry_t wr_entry,
	output logic                        full,
	input  wire logic                   pop,
	output logic                        rd_valid,
	output hcbd_pkg::queue_entry_t      rd_entry
);
	import hcbd_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	queue_entry_t    mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CntW'(Depth));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### sv/hcbd_back.sv
// ---------------------------------------------------------------------------
// hcbd_back
// Chunk framing state machine: size line parse, limit checks, data pass-through.
// ---------------------------------------------------------------------------
`default_nettype none

module hcbd_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [hcbd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hcbd_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                               q_valid,
	input  wire hcbd_pkg::queue_entry_t             q_entry,
	output logic                                    q_pop,
	hcbd_out_if.source                              result
);
	import hcbd_pkg::*;

	logic [CFG_W-1:0] max_chunk_q;
	logic [CFG_W-1:0] max_body_q;

	phase_t           phase_q;
	logic [ACC_W-1:0] acc_q;
	size_flags_t      flags_q;
	logic [CFG_W-1:0] left_q;
	logic [CFG_W-1:0] total_q;
	logic             pcr_q;

	phase_t           cur_phase;
	logic [ACC_W-1:0] cur_acc;
	size_flags_t      cur_flags;
	logic [CFG_W-1:0] cur_left;
	logic [CFG_W-1:0] cur_total;
	logic             cur_pcr;

	phase_t           phase_d;
	logic [ACC_W-1:0] acc_d;
	size_flags_t      flags_d;
	logic [CFG_W-1:0] left_d;
	logic [CFG_W-1:0] total_d;
	logic             pcr_d;

	line_step_t       cr_step;
	line_step_t       ch_step;
	logic [ACC_W-1:0] acc_shift;
	logic [ACC_W-1:0] sum_total;

	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_pvalid_q;
	logic [1:0]       out_status_q;
	logic [7:0]       pbyte_d;
	logic             pvalid_d;
	logic [1:0]       status_d;

	assign q_pop = q_valid && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chunk_q <= MAX_CHUNK_RESET;
			max_body_q  <= MAX_BODY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_CHUNK: max_chunk_q <= cfg_data;
				CFG_MAX_BODY:  max_body_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// new message clears the state before this byte is handled
	always_comb begin
		if (q_entry.new_msg) begin
			cur_phase = PH_SIZE;
			cur_acc   = '0;
			cur_flags = '0;
			cur_left  = '0;
			cur_total = '0;
			cur_pcr   = 1'b0;
		end else begin
			cur_phase = phase_q;
			cur_acc   = acc_q;
			cur_flags = flags_q;
			cur_left  = left_q;
			cur_total = total_q;
			cur_pcr   = pcr_q;
		end
	end

	// a pending cr that is not followed by lf counts as a line character
	always_comb begin
		cr_step   = cur_pcr ? line_char(cur_flags, CR_CLASS)
			: line_step_t'{flags: cur_flags, take_digit: 1'b0};
		ch_step   = line_char(cr_step.flags, q_entry.cls);
		// from 2^28 up one more digit always reaches the saturation value
		acc_shift = (cur_acc[ACC_W-1:ACC_W-5] != '0) ? ACC_SAT
			: {cur_acc[ACC_W-5:0], q_entry.cls.hex_val};
		sum_total = {1'b0, cur_total} + cur_acc;
	end

	// next state
	always_comb begin
		phase_d = cur_phase;
		acc_d   = cur_acc;
		flags_d = cur_flags;
		left_d  = cur_left;
		total_d = cur_total;
		pcr_d   = cur_pcr;
		unique case (cur_phase)
			PH_SIZE: begin
				if (cur_pcr && q_entry.cls.is_lf) begin
					pcr_d = 1'b0;
					priority if (cur_flags.bad || !cur_flags.digit
						|| (cur_acc > {1'b0, max_chunk_q})) begin
						phase_d = PH_FAILED;
					end else if (cur_acc == '0) begin
						phase_d = PH_TRAILER;
					end else if (sum_total > {1'b0, max_body_q}) begin
						phase_d = PH_FAILED;
					end else begin
						phase_d = PH_DATA;
						left_d  = cur_acc[CFG_W-1:0];
					end
				end else if (q_entry.cls.is_cr) begin
					flags_d = cr_step.flags;
					pcr_d   = 1'b1;
				end else begin
					flags_d = ch_step.flags;
					pcr_d   = 1'b0;
					if (ch_step.take_digit) acc_d = acc_shift;
				end
			end
			PH_DATA: begin
				total_d = cur_total + 1'b1;
				if (cur_left == CFG_W'(1)) begin
					phase_d = PH_SKIP;
					left_d  = SKIP_BYTES;
				end else begin
					left_d  = cur_left - 1'b1;
				end
			end
			PH_SKIP: begin
				left_d = cur_left - 1'b1;
				if (cur_left == CFG_W'(1)) begin
					phase_d = PH_SIZE;
					acc_d   = '0;
					flags_d = '0;
					pcr_d   = 1'b0;
				end
			end
			PH_TRAILER: begin
				if (cur_pcr && q_entry.cls.is_lf) phase_d = PH_DONE;
				pcr_d = q_entry.cls.is_cr;
			end
			PH_DONE, PH_FAILED: ;
			default: ;
		endcase
	end

	// result of this byte
	always_comb begin
		pvalid_d = (cur_phase == PH_DATA);
		pbyte_d  = pvalid_d ? q_entry.data : 8'h00;
		unique case (phase_d)
			PH_DONE:   status_d = STAT_DONE;
			PH_FAILED: status_d = STAT_ERROR;
			default:   status_d = STAT_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIZE;
			acc_q   <= '0;
			flags_q <= '0;
			left_q  <= '0;
			total_q <= '0;
			pcr_q   <= 1'b0;
		end else if (q_pop) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			flags_q <= flags_d;
			left_q  <= left_d;
			total_q <= total_d;
			pcr_q   <= pcr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_byte_q   <= pbyte_d;
			out_pvalid_q <= pvalid_d;
			out_status_q <= status_d;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.payload_byte  = out_byte_q;
	assign result.payload_valid = out_pvalid_q;
	assign result.status        = out_status_q;

	a_data_emits: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && (cur_phase == PH_DATA) |=> out_pvalid_q)
		else $error("data byte did not produce payload");

	a_data_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (left_q != '0))
		else $error("data phase with no bytes left");

	a_skip_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> ((left_q == CFG_W'(1)) || (left_q == CFG_W'(2))))
		else $error("skip count out of range");

	a_payload_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_pvalid_q |-> (out_status_q == STAT_RUN))
		else $error("payload byte with final status");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_pvalid_q |-> (out_byte_q == 8'h00))
		else $error("non-data result carries a byte");

endmodule

`default_nettype wire

### sv/http_chunked_body_decoder.sv
// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked body decoder: one raw byte in, one result out per byte.
// ---------------------------------------------------------------------------
//  channel   dir  payload                                  handshake
//  body      in   data_byte[7:0], new_message              valid/ready
//  result    out  payload_byte[7:0], payload_valid, status valid/ready
//  cfg       in   cfg_index, cfg_data[31:0]                cfg_we, no wait
//
//  one byte per cycle sustained while result.ready holds; each byte needs
//  a single pass through the framing state machine, whose size check (33-bit
//  add and compare) sets the path; bytes pass the queue, then the output register
//  reset clears the framing state, the queue and the output register and
//  loads max_chunk_size = 16777216, max_body_size = 67108864
//  a stalled result side fills the queue, then drops body.ready
// ---------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
	parameter int unsigned QueueDepth = hcbd_pkg::QUEUE_DEPTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	hcbd_in_if.sink                             body,
	hcbd_out_if.source                          result,
	input  wire logic                           cfg_we,
	input  wire logic [hcbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hcbd_pkg::CFG_W-1:0]     cfg_data
);
	import hcbd_pkg::*;

	logic         q_push;
	logic         q_full;
	logic         q_pop;
	logic         q_valid;
	queue_entry_t q_wr;
	queue_entry_t q_rd;

	hcbd_front u_front (
		.body  (body),
		.full  (q_full),
		.push  (q_push),
		.entry (q_wr)
	);

	hcbd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.rd_valid (q_valid),
		.rd_entry (q_rd)
	);

	hcbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (q_rd),
		.q_pop     (q_pop),
		.result    (result)
	);

endmodule

`default_nettype wire
